@@ rtl/ambfs_pkg.sv @@
`timescale 1ns / 1ps

package ambfs_pkg;

   // Widths fixed by the register map and the item fields
   localparam int VERTEX_WIDTH    = 3;
   localparam int ROW_COUNT       = 8;
   localparam int ROW_WIDTH       = 8;
   localparam int ROW_INDEX_WIDTH = 3;
   localparam int CSR_INDEX_WIDTH = 4;

   typedef logic [VERTEX_WIDTH-1:0]    vertex_type;
   typedef logic [ROW_WIDTH-1:0]       row_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   // Controller to datapath
   typedef struct packed {
      logic start;   // load start vertex, clear marks
      logic deq;     // pop queue head, fetch its fresh neighbours
      logic enq;     // push lowest fresh neighbour
      logic emit;    // load the output register
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic start_ok;
      logic fresh_empty;
      logic queue_empty;
   } dp_status_type;

endpackage

@@ rtl/ambfs_if.sv @@
`timescale 1ns / 1ps

interface ambfs_req_if;
   import ambfs_pkg::*;
   logic       valid;
   logic       ready;
   vertex_type start_vertex;

   modport source (output valid, output start_vertex, input ready);
   modport sink   (input valid, input start_vertex, output ready);
endinterface

interface ambfs_rsp_if;
   import ambfs_pkg::*;
   logic       valid;
   logic       ready;
   vertex_type visited_vertex;
   logic       last_of_walk;

   modport source (output valid, output visited_vertex, output last_of_walk, input ready);
   modport sink   (input valid, input visited_vertex, input last_of_walk, output ready);
endinterface

@@ rtl/adjacency_matrix_bfs_order_unit.sv @@
`timescale 1ns / 1ps

// Breadth-first walk over a graph of up to eight vertices whose edges sit in eight
// row registers (csr_index 0..7, bit i of row r is an edge r->i; other indexes are
// ignored). Each request names a start vertex; the block answers with one response
// per reachable vertex in visit order, the final one with last_of_walk set. A start
// at or above VERTEX_COUNT is taken and produces nothing. For each vertex reached the walk
// pops it from the pending queue, then pushes its fresh neighbours one at a time,
// lowest index first, through the single push port, and emits the vertex once none
// is left and the output register is free; the next request is taken once the last
// response has been loaded into the output register, even if it has not been taken.

module adjacency_matrix_bfs_order_unit #(
   parameter int VERTEX_COUNT = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   ambfs_req_if.sink                req_bus,
   ambfs_rsp_if.source              rsp_bus,
   input  logic                     csr_write_enable,
   input  ambfs_pkg::csr_index_type csr_index,
   input  ambfs_pkg::row_type       csr_write_data
);
   import ambfs_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   ambfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ambfs_dp #(
      .VERTEX_COUNT (VERTEX_COUNT)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_start_vertex   (req_bus.start_vertex),
      .rsp_visited_vertex (rsp_bus.visited_vertex),
      .rsp_last_of_walk   (rsp_bus.last_of_walk),
      .cmd                (cmd),
      .status             (status)
   );

endmodule

@@ rtl/ambfs_ctrl.sv @@
`timescale 1ns / 1ps

module ambfs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  ambfs_pkg::dp_status_type status,
   output ambfs_pkg::dp_cmd_type    cmd
);
   import ambfs_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DEQ,
      ST_ENQ
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.start = req_valid && status.start_ok;
         end
         ST_DEQ: begin
            cmd.deq = 1'b1;
         end
         ST_ENQ: begin
            cmd.enq  = !status.fresh_empty;
            cmd.emit = status.fresh_empty && out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               // an out-of-range start is dropped without a walk
               if (cmd.start) state_ff <= ST_DEQ;
            end
            ST_DEQ: begin
               state_ff <= ST_ENQ;
            end
            ST_ENQ: begin
               if (cmd.emit) state_ff <= status.queue_empty ? ST_IDLE : ST_DEQ;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

@@ rtl/ambfs_dp.sv @@
`timescale 1ns / 1ps

module ambfs_dp #(
   parameter int VERTEX_COUNT = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  ambfs_pkg::csr_index_type  csr_index,
   input  ambfs_pkg::row_type        csr_write_data,
   input  ambfs_pkg::vertex_type     req_start_vertex,
   output ambfs_pkg::vertex_type     rsp_visited_vertex,
   output logic                      rsp_last_of_walk,
   input  ambfs_pkg::dp_cmd_type     cmd,
   output ambfs_pkg::dp_status_type  status
);
   import ambfs_pkg::*;

   localparam int QW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
   localparam int CW = $clog2(VERTEX_COUNT + 1);
   localparam logic [VERTEX_WIDTH:0] VERTEX_LIMIT = (VERTEX_WIDTH + 1)'(VERTEX_COUNT);
   localparam logic [CW-1:0]         CNT_ONE      = CW'(1);

   row_type                   rows_ff [ROW_COUNT];
   vertex_type                queue_ff [VERTEX_COUNT];
   logic [VERTEX_COUNT-1:0]   visited_ff;
   logic [VERTEX_COUNT-1:0]   fresh_ff;
   logic [CW-1:0]             head_ff;
   logic [CW-1:0]             tail_ff;
   vertex_type                cur_ff;
   vertex_type                rsp_vertex_ff;
   logic                      rsp_last_ff;

   vertex_type                head_vertex;
   logic [VERTEX_COUNT-1:0]   pick_onehot;
   vertex_type                pick_index;

   assign head_vertex = queue_ff[head_ff[QW-1:0]];
   // lowest set bit of the fresh mask
   assign pick_onehot = fresh_ff & (~fresh_ff + {{(VERTEX_COUNT-1){1'b0}}, 1'b1});

   always_comb begin
      pick_index = '0;
      for (int i = 0; i < VERTEX_COUNT; i++) begin
         if (pick_onehot[i]) pick_index = VERTEX_WIDTH'(i);
      end
   end

   assign status.start_ok    = ({1'b0, req_start_vertex} < VERTEX_LIMIT);
   assign status.fresh_empty = (fresh_ff == '0);
   assign status.queue_empty = (head_ff == tail_ff);

   assign rsp_visited_vertex = rsp_vertex_ff;
   assign rsp_last_of_walk   = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROW_COUNT; r++) rows_ff[r] <= '0;
      end else if (csr_write_enable && (csr_index < CSR_INDEX_WIDTH'(ROW_COUNT))) begin
         rows_ff[csr_index[ROW_INDEX_WIDTH-1:0]] <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         visited_ff <= '0;
         fresh_ff   <= '0;
         head_ff    <= '0;
         tail_ff    <= '0;
      end else begin
         if (cmd.start) begin
            visited_ff <= {{(VERTEX_COUNT-1){1'b0}}, 1'b1} << req_start_vertex;
            fresh_ff   <= '0;
            head_ff    <= '0;
            tail_ff    <= CNT_ONE;
         end
         if (cmd.deq) begin
            fresh_ff <= rows_ff[head_vertex][VERTEX_COUNT-1:0] & ~visited_ff;
            head_ff  <= head_ff + CNT_ONE;
         end
         if (cmd.enq) begin
            visited_ff <= visited_ff | pick_onehot;
            fresh_ff   <= fresh_ff & ~pick_onehot;
            tail_ff    <= tail_ff + CNT_ONE;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (cmd.start) queue_ff[0] <= req_start_vertex;
      if (cmd.enq)   queue_ff[tail_ff[QW-1:0]] <= pick_index;
      if (cmd.deq)   cur_ff <= head_vertex;
      if (cmd.emit) begin
         rsp_vertex_ff <= cur_ff;
         rsp_last_ff   <= (head_ff == tail_ff);
      end
   end

endmodule

@@ rtl/ambfs_checker.sv @@
`timescale 1ns / 1ps

module ambfs_checker #(
   parameter int VERTEX_COUNT = 8
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input ambfs_pkg::vertex_type req_start_vertex,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input ambfs_pkg::vertex_type rsp_visited_vertex,
   input logic                  rsp_last_of_walk
);
   import ambfs_pkg::*;

   localparam logic [VERTEX_WIDTH:0] VERTEX_LIMIT = (VERTEX_WIDTH + 1)'(VERTEX_COUNT);

   logic req_take;
   logic start_ok;

   assign req_take = req_valid && req_ready;
   assign start_ok = ({1'b0, req_start_vertex} < VERTEX_LIMIT);

   // a valid start begins a walk, so no further request is taken next cycle
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      req_take && start_ok |=> !req_ready)
      else $error("request taken while a walk was starting");

   // a start outside the graph is dropped and the block stays free
   a_drop_bad_start: assert property (@(posedge clock) disable iff (reset)
      req_take && !start_ok |=> req_ready && !$rose(rsp_valid))
      else $error("out-of-range start did not leave the block idle");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response withdrawn before it was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_visited_vertex) && $stable(rsp_last_of_walk))
      else $error("stalled response changed");

endmodule

bind adjacency_matrix_bfs_order_unit ambfs_checker #(
   .VERTEX_COUNT (VERTEX_COUNT)
) u_ambfs_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .req_start_vertex   (req_bus.start_vertex),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_visited_vertex (rsp_bus.visited_vertex),
   .rsp_last_of_walk   (rsp_bus.last_of_walk)
);
